// ----- hw/rtl/zfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// zfsa_pkg
// Shared types and constants of the zoned frame stack allocator: request and
// response layouts, request kinds, status codes and register map.
// ----------------------------------------------------------------------------
package zfsa_pkg;

   // Sizing
   localparam int ZONE_COUNT  = 3;
   localparam int STACK_DEPTH = 1024;
   localparam int FRAME_BITS  = 40;

   localparam int FIELD_BITS  = 40;
   localparam int ZONE_BITS   = 2;
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 2;

   localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);
   localparam int IDX_BITS    = $clog2(STACK_DEPTH);
   localparam int MEM_DEPTH   = ZONE_COUNT * STACK_DEPTH;
   localparam int ADDR_BITS   = $clog2(MEM_DEPTH);

   localparam logic [FIELD_BITS-1:0] FRAME_MASK = (FRAME_BITS >= FIELD_BITS) ? '1 :
      FIELD_BITS'((64'd1 << FRAME_BITS) - 64'd1);

   // Register map
   localparam int REG_COUNT     = 3;
   localparam int REG_BITS      = 40;
   localparam int REG_IDX_BITS  = 2;
   localparam int REG_ADDR_LSB  = 3;
   localparam int CSR_ADDR_BITS = REG_IDX_BITS + REG_ADDR_LSB;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [REG_IDX_BITS-1:0] REG_ZONE0_LIMIT = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_ZONE1_LIMIT = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_ZONE2_LIMIT = 2'd2;

   localparam logic [REG_BITS-1:0] ZONE0_LIMIT_RST = 40'd4095;
   localparam logic [REG_BITS-1:0] ZONE1_LIMIT_RST = 40'd1048575;
   localparam logic [REG_BITS-1:0] ZONE2_LIMIT_RST = '1;

   // Request kinds
   localparam logic [KIND_BITS-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_SEED  = 2'd2;

   // Response status
   localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_OOM   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_ABOVE = 2'd2;
   localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd3;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [ZONE_BITS-1:0]  max_zone;
      logic [FIELD_BITS-1:0] frame_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [FIELD_BITS-1:0]  frame_out;
      logic [ZONE_BITS-1:0]   zone;
      logic                   needs_zeroing;
   } rsp_type;

   typedef logic [REG_COUNT-1:0][REG_BITS-1:0] limits_type;

endpackage

// ----- hw/rtl/zoned_frame_stack_allocator_top.sv -----
// ----------------------------------------------------------------------------
// zoned_frame_stack_allocator_top
// Page-frame allocator with a fresh and a used frame stack per address zone.
// ----------------------------------------------------------------------------
// Each request yields exactly one response. An allocate request searches from
// its max_zone (clamped to the last zone) down to zone 0 and pops the top
// frame of the first zone holding any, taking the fresh stack first and
// otherwise the used stack with needs_zeroing set. Free and seed requests push
// frame_in onto the used or fresh stack of the lowest zone whose limit covers
// it; a frame above all limits answers "above all zones" and a full target
// stack answers "stack full", with nothing stored. Requests are handled one
// at a time: free and seed requests load their response from the execute
// state, an allocate request that finds a frame from a following read state
// that holds the registered read of the stack memory. req_ready returns at
// the same edge that loads the response, so a new request is taken only
// after the last one has loaded its response; a stalled response holds the
// engine once the next request reaches the point of loading its own
// response. Stack memories come up undefined and need no clearing pass; only
// entries below a stack's count are ever read. Zone limits are written
// through the register port at byte addresses 0, 8 and 16 (64-bit data, low
// 40 bits used) and should only be changed while no request is in flight.
// ----------------------------------------------------------------------------
module zoned_frame_stack_allocator_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  zfsa_pkg::req_type                   req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output zfsa_pkg::rsp_type                   rsp_data,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [zfsa_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [zfsa_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [zfsa_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   // zone limits, held in the register block
   zfsa_pkg::limits_type zone_limits;

   zfsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .zone_limits (zone_limits)
   );

   // sequencer, stack counts and frame memories
   zfsa_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .zone_limits (zone_limits),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- hw/rtl/zfsa_csr.sv -----
// ----------------------------------------------------------------------------
// zfsa_csr
// APB-style register block holding the three zone limit registers.
// ----------------------------------------------------------------------------
module zfsa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [zfsa_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [zfsa_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [zfsa_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output zfsa_pkg::limits_type                zone_limits
);

   zfsa_pkg::limits_type limits_ff;
   zfsa_pkg::limits_type limits_in;
   logic [zfsa_pkg::REG_IDX_BITS-1:0] reg_idx;
   logic wr_en;

   assign reg_idx    = csr_paddr[zfsa_pkg::CSR_ADDR_BITS-1:zfsa_pkg::REG_ADDR_LSB];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      limits_in = limits_ff;
      if (wr_en) begin
         unique case (reg_idx)
            zfsa_pkg::REG_ZONE0_LIMIT: limits_in[0] = csr_pwdata[zfsa_pkg::REG_BITS-1:0];
            zfsa_pkg::REG_ZONE1_LIMIT: limits_in[1] = csr_pwdata[zfsa_pkg::REG_BITS-1:0];
            zfsa_pkg::REG_ZONE2_LIMIT: limits_in[2] = csr_pwdata[zfsa_pkg::REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         zfsa_pkg::REG_ZONE0_LIMIT:
            csr_prdata = zfsa_pkg::CSR_DATA_BITS'(limits_ff[0]);
         zfsa_pkg::REG_ZONE1_LIMIT:
            csr_prdata = zfsa_pkg::CSR_DATA_BITS'(limits_ff[1]);
         zfsa_pkg::REG_ZONE2_LIMIT:
            csr_prdata = zfsa_pkg::CSR_DATA_BITS'(limits_ff[2]);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff[0] <= zfsa_pkg::ZONE0_LIMIT_RST;
         limits_ff[1] <= zfsa_pkg::ZONE1_LIMIT_RST;
         limits_ff[2] <= zfsa_pkg::ZONE2_LIMIT_RST;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign zone_limits = limits_ff;

endmodule

// ----- hw/rtl/zfsa_engine.sv -----
// ----------------------------------------------------------------------------
// zfsa_engine
// Request sequencer: per-zone stack counts, fresh and used frame memories,
// zone search and the response register.
// ----------------------------------------------------------------------------
module zfsa_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  zfsa_pkg::limits_type zone_limits,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  zfsa_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output zfsa_pkg::rsp_type    rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;

   localparam int CB = zfsa_pkg::COUNT_BITS;
   localparam int ZB = zfsa_pkg::ZONE_BITS;
   localparam int FB = zfsa_pkg::FIELD_BITS;
   localparam int AB = zfsa_pkg::ADDR_BITS;

   logic [1:0] state_ff, state_in;
   zfsa_pkg::req_type req_ff;
   zfsa_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_load;

   logic [CB-1:0] fresh_cnt_ff [zfsa_pkg::ZONE_COUNT];
   logic [CB-1:0] fresh_cnt_in [zfsa_pkg::ZONE_COUNT];
   logic [CB-1:0] used_cnt_ff  [zfsa_pkg::ZONE_COUNT];
   logic [CB-1:0] used_cnt_in  [zfsa_pkg::ZONE_COUNT];

   logic [FB-1:0] fresh_mem [zfsa_pkg::MEM_DEPTH];
   logic [FB-1:0] used_mem  [zfsa_pkg::MEM_DEPTH];
   logic [FB-1:0] fresh_rd_ff, used_rd_ff;

   logic [ZB-1:0] pend_zone_ff, pend_zone_in;
   logic          pend_nz_ff, pend_nz_in;

   logic          slot_free;
   logic [FB-1:0] frame_m;
   logic [ZB-1:0] max_sat;

   // allocation search
   logic          a_found;
   logic          a_fresh;
   logic [ZB-1:0] a_zone;
   logic [CB-1:0] a_cnt;

   // free / seed placement
   logic          p_found;
   logic [ZB-1:0] p_zone;
   logic [CB-1:0] p_fresh_cnt, p_used_cnt, p_cnt;
   logic          p_full;
   logic [FB-1:0] lim;

   logic [zfsa_pkg::IDX_BITS-1:0] mem_idx;
   logic [AB-1:0] mem_addr;
   logic          fresh_we, used_we, fresh_re, used_re;
   logic          cnt_dec, cnt_inc, cnt_fresh;
   logic [ZB-1:0] cnt_zone;

   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign frame_m   = req_ff.frame_in & zfsa_pkg::FRAME_MASK;
   assign max_sat   = (int'(req_ff.max_zone) >= zfsa_pkg::ZONE_COUNT) ?
                      ZB'(zfsa_pkg::ZONE_COUNT - 1) : req_ff.max_zone;

   // Highest eligible zone holding any frame wins.
   always_comb begin
      a_found = 1'b0;
      a_fresh = 1'b0;
      a_zone  = '0;
      a_cnt   = '0;
      for (int z = 0; z < zfsa_pkg::ZONE_COUNT; z++) begin
         if (z <= int'(max_sat) &&
             (fresh_cnt_ff[z] != '0 || used_cnt_ff[z] != '0)) begin
            a_found = 1'b1;
            a_zone  = ZB'(z);
            a_fresh = (fresh_cnt_ff[z] != '0);
            a_cnt   = (fresh_cnt_ff[z] != '0) ? fresh_cnt_ff[z] : used_cnt_ff[z];
         end
      end
   end

   // Lowest zone whose limit covers the frame wins.
   always_comb begin
      p_found     = 1'b0;
      p_zone      = '0;
      p_fresh_cnt = '0;
      p_used_cnt  = '0;
      lim         = '0;
      for (int z = zfsa_pkg::ZONE_COUNT - 1; z >= 0; z--) begin
         lim = (z < zfsa_pkg::REG_COUNT) ? zone_limits[z] : zfsa_pkg::FRAME_MASK;
         if (frame_m <= lim) begin
            p_found     = 1'b1;
            p_zone      = ZB'(z);
            p_fresh_cnt = fresh_cnt_ff[z];
            p_used_cnt  = used_cnt_ff[z];
         end
      end
   end

   assign p_cnt  = (req_ff.kind == zfsa_pkg::KIND_FREE) ? p_used_cnt : p_fresh_cnt;
   assign p_full = (p_cnt == CB'(zfsa_pkg::STACK_DEPTH));

   always_comb begin
      if (req_ff.kind == zfsa_pkg::KIND_ALLOC) begin
         mem_idx  = zfsa_pkg::IDX_BITS'(a_cnt - CB'(1));
         mem_addr = AB'(a_zone) * AB'(zfsa_pkg::STACK_DEPTH) + AB'(mem_idx);
      end else begin
         mem_idx  = zfsa_pkg::IDX_BITS'(p_cnt);
         mem_addr = AB'(p_zone) * AB'(zfsa_pkg::STACK_DEPTH) + AB'(mem_idx);
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_load     = 1'b0;
      rsp_in       = rsp_ff;
      fresh_we     = 1'b0;
      used_we      = 1'b0;
      fresh_re     = 1'b0;
      used_re      = 1'b0;
      cnt_dec      = 1'b0;
      cnt_inc      = 1'b0;
      cnt_fresh    = 1'b0;
      cnt_zone     = '0;
      pend_zone_in = pend_zone_ff;
      pend_nz_in   = pend_nz_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (req_ff.kind) inside
               zfsa_pkg::KIND_ALLOC: begin
                  if (a_found) begin
                     fresh_re     = a_fresh;
                     used_re      = !a_fresh;
                     cnt_dec      = 1'b1;
                     cnt_fresh    = a_fresh;
                     cnt_zone     = a_zone;
                     pend_zone_in = a_zone;
                     pend_nz_in   = !a_fresh;
                     state_in     = ST_READ;
                  end else if (slot_free) begin
                     rsp_load = 1'b1;
                     rsp_in   = '{status: zfsa_pkg::STAT_OOM, frame_out: '0,
                                  zone: '0, needs_zeroing: 1'b0};
                     state_in = ST_IDLE;
                  end
               end
               zfsa_pkg::KIND_FREE, zfsa_pkg::KIND_SEED: begin
                  if (slot_free) begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                     if (!p_found) begin
                        rsp_in = '{status: zfsa_pkg::STAT_ABOVE, frame_out: '0,
                                   zone: '0, needs_zeroing: 1'b0};
                     end else if (p_full) begin
                        rsp_in = '{status: zfsa_pkg::STAT_FULL, frame_out: '0,
                                   zone: p_zone, needs_zeroing: 1'b0};
                     end else begin
                        rsp_in    = '{status: zfsa_pkg::STAT_OK, frame_out: '0,
                                      zone: p_zone, needs_zeroing: 1'b0};
                        used_we   = (req_ff.kind == zfsa_pkg::KIND_FREE);
                        fresh_we  = (req_ff.kind == zfsa_pkg::KIND_SEED);
                        cnt_inc   = 1'b1;
                        cnt_fresh = (req_ff.kind == zfsa_pkg::KIND_SEED);
                        cnt_zone  = p_zone;
                     end
                  end
               end
               default: begin
                  if (slot_free) begin
                     rsp_load = 1'b1;
                     rsp_in   = '{status: zfsa_pkg::STAT_OK, frame_out: '0,
                                  zone: '0, needs_zeroing: 1'b0};
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_READ: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               rsp_in   = '{status: zfsa_pkg::STAT_OK,
                            frame_out: pend_nz_ff ? used_rd_ff : fresh_rd_ff,
                            zone: pend_zone_ff, needs_zeroing: pend_nz_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int z = 0; z < zfsa_pkg::ZONE_COUNT; z++) begin
         fresh_cnt_in[z] = fresh_cnt_ff[z];
         used_cnt_in[z]  = used_cnt_ff[z];
         if (cnt_zone == ZB'(z)) begin
            if (cnt_fresh) begin
               if (cnt_dec) fresh_cnt_in[z] = fresh_cnt_ff[z] - CB'(1);
               if (cnt_inc) fresh_cnt_in[z] = fresh_cnt_ff[z] + CB'(1);
            end else begin
               if (cnt_dec) used_cnt_in[z] = used_cnt_ff[z] - CB'(1);
               if (cnt_inc) used_cnt_in[z] = used_cnt_ff[z] + CB'(1);
            end
         end
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int z = 0; z < zfsa_pkg::ZONE_COUNT; z++) begin
            fresh_cnt_ff[z] <= '0;
            used_cnt_ff[z]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fresh_cnt_ff <= fresh_cnt_in;
         used_cnt_ff  <= used_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      pend_zone_ff <= pend_zone_in;
      pend_nz_ff   <= pend_nz_in;
   end

   always_ff @(posedge clock) begin
      if (fresh_we) begin
         fresh_mem[mem_addr] <= frame_m;
      end
      if (fresh_re) begin
         fresh_rd_ff <= fresh_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[mem_addr] <= frame_m;
      end
      if (used_re) begin
         used_rd_ff <= used_mem[mem_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/zfsa_checker.sv -----
// ----------------------------------------------------------------------------
// zfsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module zfsa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input zfsa_pkg::rsp_type                   rsp_data,
   input logic                                csr_pready
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // one request in flight: busy right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in flight");

   // failed outcomes carry no frame and no zeroing flag
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != zfsa_pkg::STAT_OK |->
         rsp_data.frame_out == '0 && !rsp_data.needs_zeroing)
      else $error("failed response carries frame data");

   // out of memory always reports zone 0
   a_oom_zone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == zfsa_pkg::STAT_OOM |-> rsp_data.zone == '0)
      else $error("out-of-memory response with nonzero zone");

   // register port never stalls
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind zoned_frame_stack_allocator_top zfsa_checker u_zfsa_checker (.*);
